FILE: rtl/core/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants of the trapezoid path timing unit.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int CfgW = 23;

  localparam logic [1:0] REG_CRUISE   = 2'd0;
  localparam logic [1:0] REG_MIN_STEP = 2'd1;
  localparam logic [1:0] REG_ACCEL    = 2'd2;

  localparam logic [22:0] CRUISE_RST   = 23'd131072;
  localparam logic [19:0] MIN_STEP_RST = 20'd3277;
  localparam logic [22:0] ACCEL_RST    = 23'd98304;

  // 0.1 in Q16.16
  localparam logic [31:0] SPEED_FLOOR = 32'd6554;

  // One stored waypoint: position, quaternion and length of incoming segment
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [3:0][15:0] att;
    logic [31:0]      len;
  } tpt_entry_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_SQ,
    ST_LD_ROOT,
    ST_LD_RWAIT,
    ST_LD_WR,
    ST_CL_CHK,
    ST_CL_VV,
    ST_CL_DIV,
    ST_CL_DWAIT,
    ST_EM_RD0,
    ST_EM_LAT0,
    ST_EM_RD,
    ST_EM_LAT,
    ST_EM_CUM,
    ST_EM_SPD,
    ST_EM_ROOT,
    ST_EM_RWAIT,
    ST_EM_VEL,
    ST_EM_VMUL,
    ST_EM_VDIV,
    ST_EM_VWAIT,
    ST_EM_SDIV,
    ST_EM_SWAIT,
    ST_EM_OUT
  } tpt_state_t;

endpackage

FILE: rtl/core/trapezoid_path_timing_unit.sv
// ----------------------------------------------------------------------------
// trapezoid_path_timing_unit
// Stores a path of waypoints, then emits per point a start time, the pose
// and a velocity along the next segment from a trapezoidal speed profile.
// ----------------------------------------------------------------------------
//  channel | signals                                    | direction
//  in      | in_valid, in_stall, in_way_*, in_path_end  | waypoint beats in
//  out     | out_valid, out_stall, out_*                | timed point beats out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | register writes in
//
//  A stored waypoint takes 3 squares and a 32-step square root between
//  beats; the first one and a dropped one skip these steps.
//  Closing a path runs the ramp division, then per point up to a 32-step
//  root and four 64-step divisions on the shared divider, plus one extra
//  read once for the first point.
//  Reset is synchronous; the store needs no clearing.
//  in_stall is low only while idle; an emitted point waits in the output
//  register while out_stall is high, and the sequencer holds in its emit
//  step until the register is free.
// ----------------------------------------------------------------------------
module trapezoid_path_timing_unit
  import tpt_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_way_x,
  input  logic signed [31:0]  in_way_y,
  input  logic signed [31:0]  in_way_z,
  input  logic signed [15:0]  in_way_qx,
  input  logic signed [15:0]  in_way_qy,
  input  logic signed [15:0]  in_way_qz,
  input  logic signed [15:0]  in_way_qw,
  input  logic                in_path_end,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         out_point_time,
  output logic signed [31:0]  out_point_x,
  output logic signed [31:0]  out_point_y,
  output logic signed [31:0]  out_point_z,
  output logic signed [15:0]  out_point_qx,
  output logic signed [15:0]  out_point_qy,
  output logic signed [15:0]  out_point_qz,
  output logic signed [15:0]  out_point_qw,
  output logic signed [31:0]  out_vel_x,
  output logic signed [31:0]  out_vel_y,
  output logic signed [31:0]  out_vel_z,
  output logic                out_final_point,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {33'd0, a} + {1'b0, b};
    return (s[64:32] != '0) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [32:0] sdiff(input logic [31:0] a, input logic [31:0] b);
    return {b[31], b} - {a[31], a};
  endfunction

  function automatic logic [31:0] mag(input logic [32:0] d);
    logic [32:0] n;
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  // configuration
  logic [22:0] cruise_r;
  logic [19:0] min_step_r;
  logic [22:0] accel_r;

  // control and path state
  tpt_state_t       state_r, state_nxt;
  logic [CW-1:0]    cnt_r;
  logic [CW-1:0]    idx_r;
  logic [31:0]      path_r;
  logic [31:0]      ramp_r;
  logic [31:0]      decel_r;
  logic [31:0]      elapsed_r;
  logic [31:0]      el_nxt_r;
  logic [31:0]      cum_r;
  logic [1:0]       k_r;

  // captured waypoint
  logic [2:0][31:0] in_pos_r;
  logic [3:0][15:0] in_att_r;
  logic             in_end_r;
  logic [2:0][31:0] prev_pos_r;
  logic [65:0]      acc_r;
  logic [31:0]      seg_r;

  // emission operands
  tpt_entry_t       cur_r;
  tpt_entry_t       nxt_r;
  logic [31:0]      spd_r;
  logic [2:0][31:0] vel_r;

  logic [63:0]      prod_r;

  // output register
  logic             out_valid_r;
  logic [31:0]      o_time_r;
  tpt_entry_t       o_ent_r;
  logic [2:0][31:0] o_vel_r;
  logic             o_final_r;

  // shared units
  logic        sqrt_start, sqrt_busy;
  logic [63:0] sqrt_rad;
  logic [31:0] sqrt_root;
  logic        div_start, div_busy;
  logic [63:0] div_num, div_quot;
  logic [31:0] div_den;

  logic        mem_we;
  tpt_entry_t  mem_wdata, mem_rdata;
  logic [AW-1:0] mem_raddr;

  logic [31:0] mul_a, mul_b;
  logic        mul_en;

  logic [22:0] acc_eff;
  logic [23:0] two_acc;
  logic [CW-1:0] idx_inc;
  logic        has_nxt;
  logic        full;
  logic        in_acc;
  logic        cum_lo, cum_hi;
  logic [31:0] dsel;
  logic [31:0] cum_cl;
  logic [32:0] ax_d;
  logic [31:0] ramp_q;
  logic [31:0] ramp_c;
  logic [31:0] spd_fl;
  logic [63:0] step_q;
  logic [31:0] vel_sat;
  logic [31:0] neg_c;

  assign acc_eff = (accel_r == '0) ? 23'd1 : accel_r;
  assign two_acc = {acc_eff, 1'b0};
  assign idx_inc = idx_r + CW'(1);
  assign has_nxt = (idx_inc < cnt_r);
  assign full    = (cnt_r >= CW'(MAX_POINTS));
  assign in_acc  = in_valid && !in_stall;
  assign cum_lo  = (cum_r < ramp_r);
  assign cum_hi  = (cum_r > decel_r);
  assign cum_cl  = (cum_r > path_r) ? path_r : cum_r;
  assign dsel    = cum_lo ? cum_r : (path_r - cum_cl);
  assign ax_d    = sdiff(cur_r.pos[k_r], nxt_r.pos[k_r]);
  assign spd_fl  = (spd_r < SPEED_FLOOR) ? SPEED_FLOOR : spd_r;

  assign ramp_q  = (div_quot[63:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
  assign ramp_c  = ({ramp_q, 1'b0} > {1'b0, path_r}) ? {1'b0, path_r[31:1]} : ramp_q;
  assign step_q  = (div_quot < {44'd0, min_step_r}) ? {44'd0, min_step_r} : div_quot;
  assign neg_c   = (div_quot > 64'h8000_0000) ? 32'h8000_0000 : div_quot[31:0];
  assign vel_sat = ax_d[32] ? (32'd0 - neg_c)
                 : ((div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quot[31:0]);

  tpt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  tpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  tpt_mem #(
    .Depth (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            state_nxt = in_path_end ? ST_CL_CHK : ST_IDLE;
          end else if (cnt_r == '0) begin
            state_nxt = ST_LD_WR;
          end else begin
            state_nxt = ST_LD_SQ;
          end
        end
      end
      ST_LD_SQ:    if (k_r == 2'd3) state_nxt = ST_LD_ROOT;
      ST_LD_ROOT:  state_nxt = ST_LD_RWAIT;
      ST_LD_RWAIT: if (!sqrt_busy) state_nxt = ST_LD_WR;
      ST_LD_WR:    state_nxt = in_end_r ? ST_CL_CHK : ST_IDLE;
      ST_CL_CHK:   state_nxt = (path_r == '0) ? ST_IDLE : ST_CL_VV;
      ST_CL_VV:    state_nxt = ST_CL_DIV;
      ST_CL_DIV:   state_nxt = ST_CL_DWAIT;
      ST_CL_DWAIT: if (!div_busy) state_nxt = ST_EM_RD0;
      ST_EM_RD0:   state_nxt = ST_EM_LAT0;
      ST_EM_LAT0:  state_nxt = ST_EM_RD;
      ST_EM_RD:    state_nxt = ST_EM_LAT;
      ST_EM_LAT:   state_nxt = ST_EM_CUM;
      ST_EM_CUM:   state_nxt = ST_EM_SPD;
      ST_EM_SPD:   state_nxt = (cum_lo || cum_hi) ? ST_EM_ROOT : ST_EM_VEL;
      ST_EM_ROOT:  state_nxt = ST_EM_RWAIT;
      ST_EM_RWAIT: if (!sqrt_busy) state_nxt = ST_EM_VEL;
      ST_EM_VEL: begin
        if (!has_nxt) begin
          state_nxt = ST_EM_OUT;
        end else if (nxt_r.len == '0) begin
          state_nxt = ST_EM_SDIV;
        end else begin
          state_nxt = ST_EM_VMUL;
        end
      end
      ST_EM_VMUL:  state_nxt = ST_EM_VDIV;
      ST_EM_VDIV:  state_nxt = ST_EM_VWAIT;
      ST_EM_VWAIT: begin
        if (!div_busy) state_nxt = (k_r == 2'd2) ? ST_EM_SDIV : ST_EM_VMUL;
      end
      ST_EM_SDIV:  state_nxt = ST_EM_SWAIT;
      ST_EM_SWAIT: if (!div_busy) state_nxt = ST_EM_OUT;
      ST_EM_OUT: begin
        if (!out_valid_r) state_nxt = has_nxt ? ST_EM_RD : ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // unit strobes and operand selection
  always_comb begin
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    sqrt_rad   = prod_r;
    div_start  = 1'b0;
    div_num    = prod_r;
    div_den    = nxt_r.len;
    mem_we     = 1'b0;
    mem_raddr  = idx_inc[AW-1:0];
    case (state_r)
      ST_LD_SQ: begin
        mul_en = (k_r != 2'd3);
        mul_a  = mag(sdiff(prev_pos_r[k_r], in_pos_r[k_r]));
        mul_b  = mul_a;
      end
      ST_LD_ROOT: begin
        sqrt_start = 1'b1;
        sqrt_rad   = acc_r[63:0];
      end
      ST_LD_WR:   mem_we = 1'b1;
      ST_CL_VV: begin
        mul_en = 1'b1;
        mul_a  = {9'd0, cruise_r};
        mul_b  = mul_a;
      end
      ST_CL_DIV: begin
        div_start = 1'b1;
        div_den   = {8'd0, two_acc};
      end
      ST_EM_RD0:  mem_raddr = '0;
      ST_EM_SPD: begin
        mul_en = 1'b1;
        mul_a  = {8'd0, two_acc};
        mul_b  = dsel;
      end
      ST_EM_ROOT: sqrt_start = 1'b1;
      ST_EM_VMUL: begin
        mul_en = 1'b1;
        mul_a  = mag(ax_d);
        mul_b  = spd_r;
      end
      ST_EM_VDIV: div_start = 1'b1;
      ST_EM_SDIV: begin
        div_start = 1'b1;
        div_num   = {16'd0, nxt_r.len, 16'd0};
        div_den   = spd_fl;
      end
      default: ;
    endcase
  end

  assign mem_wdata.pos = in_pos_r;
  assign mem_wdata.att = in_att_r;
  assign mem_wdata.len = seg_r;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      path_r      <= '0;
      ramp_r      <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
      cruise_r    <= CRUISE_RST;
      min_step_r  <= MIN_STEP_RST;
      accel_r     <= ACCEL_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRUISE:   cruise_r   <= cfg_data[22:0];
          REG_MIN_STEP: min_step_r <= cfg_data[19:0];
          REG_ACCEL:    accel_r    <= cfg_data[22:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LD_WR: begin
          cnt_r  <= cnt_r + CW'(1);
          path_r <= sat_add(path_r, {32'd0, seg_r});
        end
        ST_CL_CHK: begin
          if (path_r == '0) begin
            cnt_r <= '0;
          end
        end
        ST_CL_DWAIT: begin
          if (!div_busy) begin
            ramp_r    <= ramp_c;
            elapsed_r <= '0;
          end
        end
        ST_EM_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
            elapsed_r   <= el_nxt_r;
            if (!has_nxt) begin
              cnt_r  <= '0;
              path_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          in_pos_r <= {in_way_z, in_way_y, in_way_x};
          in_att_r <= {in_way_qw, in_way_qz, in_way_qy, in_way_qx};
          in_end_r <= in_path_end;
          acc_r    <= '0;
          seg_r    <= '0;
          k_r      <= '0;
        end
      end
      ST_LD_SQ: begin
        k_r <= k_r + 2'd1;
        if (k_r != 2'd0) begin
          acc_r <= acc_r + {2'd0, prod_r};
        end
      end
      ST_LD_RWAIT: begin
        if (!sqrt_busy) begin
          seg_r <= (acc_r[65:64] != '0) ? 32'hFFFF_FFFF : sqrt_root;
        end
      end
      ST_LD_WR:    prev_pos_r <= in_pos_r;
      ST_CL_DWAIT: begin
        decel_r <= path_r - ramp_c;
        cum_r   <= '0;
        idx_r   <= '0;
      end
      ST_EM_LAT0:  cur_r <= mem_rdata;
      ST_EM_LAT:   nxt_r <= mem_rdata;
      ST_EM_CUM: begin
        cum_r <= sat_add(cum_r, {32'd0, cur_r.len});
        vel_r <= '0;
        k_r   <= '0;
      end
      ST_EM_SPD:   spd_r <= {9'd0, cruise_r};
      ST_EM_RWAIT: begin
        if (!sqrt_busy) begin
          spd_r <= (sqrt_root < SPEED_FLOOR) ? SPEED_FLOOR : sqrt_root;
        end
      end
      ST_EM_VEL:   el_nxt_r <= elapsed_r;
      ST_EM_VWAIT: begin
        if (!div_busy) begin
          vel_r[k_r] <= vel_sat;
          k_r        <= k_r + 2'd1;
        end
      end
      ST_EM_SWAIT: begin
        if (!div_busy) begin
          el_nxt_r <= sat_add(elapsed_r, step_q);
        end
      end
      ST_EM_OUT: begin
        if (!out_valid_r) begin
          o_time_r  <= elapsed_r;
          o_ent_r   <= cur_r;
          o_vel_r   <= vel_r;
          o_final_r <= !has_nxt;
          cur_r     <= nxt_r;
          idx_r     <= idx_inc;
        end
      end
      default: ;
    endcase
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_point_time  = o_time_r;
  assign out_point_x     = o_ent_r.pos[0];
  assign out_point_y     = o_ent_r.pos[1];
  assign out_point_z     = o_ent_r.pos[2];
  assign out_point_qx    = o_ent_r.att[0];
  assign out_point_qy    = o_ent_r.att[1];
  assign out_point_qz    = o_ent_r.att[2];
  assign out_point_qw    = o_ent_r.att[3];
  assign out_vel_x       = o_vel_r[0];
  assign out_vel_y       = o_vel_r[1];
  assign out_vel_z       = o_vel_r[2];
  assign out_final_point = o_final_r;

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EM_OUT))
    else $error("result beat raised outside emit step");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("stored count beyond capacity");

  a_ramp_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_CUM) |-> ({ramp_r, 1'b0} <= {1'b0, path_r}))
    else $error("ramp longer than half the path");

  a_idle_after_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && !in_path_end) |=> (state_r == ST_IDLE))
    else $error("dropped waypoint did not return to idle");

endmodule

FILE: rtl/core/tpt_sqrt.sv
// ----------------------------------------------------------------------------
// tpt_sqrt
// Iterative integer square root, 64-bit radicand, one root bit per cycle.
// ----------------------------------------------------------------------------
module tpt_sqrt
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic [31:0] root
);

  logic [63:0] rad_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;

  logic [35:0] cand;
  logic [35:0] trial;
  logic        take;

  assign cand  = {rem_r, rad_r[63:62]};
  assign trial = {2'b00, root_r, 2'b01};
  assign take  = (cand >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (take) begin
        rem_r  <= 34'(cand - trial);
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= cand[33:0];
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: rtl/core/tpt_div.sv
// ----------------------------------------------------------------------------
// tpt_div
// Restoring divider, 64-bit dividend by nonzero 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpt_div
  import tpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic [5:0]  cnt_r;
  logic        busy_r;

  logic [32:0] cand;
  logic        take;

  assign cand = {rem_r, q_r[63]};
  assign take = (cand >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (take) begin
        rem_r <= 32'(cand - {1'b0, den_r});
      end else begin
        rem_r <= cand[31:0];
      end
      q_r <= {q_r[62:0], take};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

FILE: rtl/core/tpt_mem.sv
// ----------------------------------------------------------------------------
// tpt_mem
// Waypoint store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tpt_mem
  import tpt_pkg::*;
#(
  parameter int Depth = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  tpt_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output tpt_entry_t    rdata
);

  tpt_entry_t mem [Depth];
  tpt_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
